FILE: design/swept_tone_decay_generator_assert.svh
// ----------------------------------------------------------------------------
// swept tone decay generator assertion macros
// concurrent checks on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef SWEPT_TONE_DECAY_GENERATOR_ASSERT_SVH
`define SWEPT_TONE_DECAY_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define STDG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stdg assertion failed");

// next-cycle implication
`define STDG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stdg assertion failed");

`else

`define STDG_ASSERT_NOW(lbl, ante, cons)
`define STDG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/stdg_pkg.sv
// ----------------------------------------------------------------------------
// stdg_pkg
// shared types, constants and the sine table generator of the tone voice
// ----------------------------------------------------------------------------
package stdg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam int COUNT_W = 15;
  localparam int STEP_W  = 40;
  localparam int AMP_W   = 16;
  localparam int MIX_W   = 18;
  localparam int PCM_W   = 16;
  localparam int PHASE_W = 32;
  localparam int SINE_W  = 16;

  localparam int FULL_SCALE  = 32000;
  localparam int MIX_LIMIT   = 131071;
  localparam int MAX_SAMPLES = 32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 3'd0,
    CFG_START_STEP   = 3'd1,
    CFG_SWEEP_DELTA  = 3'd2,
    CFG_TONE_AMP     = 3'd3,
    CFG_DECAY_FACTOR = 3'd4,
    CFG_SQUARE_MODE  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_t;

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // quarter-wave entry k: degree 11 taylor series in q30, scaled to 32000
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                      input int table_bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    x    = (64'(k) * 64'd4 * HALF_PI_Q30) >> table_bits;
    term = x;
    sum  = $signed(x);
    term = q30_mul(q30_mul(term, x), x) / 64'd6;
    sum  = sum - $signed(term);
    term = q30_mul(q30_mul(term, x), x) / 64'd20;
    sum  = sum + $signed(term);
    term = q30_mul(q30_mul(term, x), x) / 64'd42;
    sum  = sum - $signed(term);
    term = q30_mul(q30_mul(term, x), x) / 64'd72;
    sum  = sum + $signed(term);
    term = q30_mul(q30_mul(term, x), x) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) * 64'd32000 + 64'd536870912) >> 30;
    return r[SINE_W-1:0];
  endfunction

endpackage

FILE: design/stdg_in_if.sv
// ----------------------------------------------------------------------------
// stdg_in_if
// request channel: start or sample tick, with the incoming mix value
// ----------------------------------------------------------------------------
interface stdg_in_if
  import stdg_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [MIX_W-1:0] mix_in;

  modport source (output valid, output req_type, output mix_in, input ready);
  modport sink (input valid, input req_type, input mix_in, output ready);
endinterface

FILE: design/stdg_out_if.sv
// ----------------------------------------------------------------------------
// stdg_out_if
// result channel: mixed sample, pcm sample and end-of-sound flag
// ----------------------------------------------------------------------------
interface stdg_out_if
  import stdg_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] mix_out;
  logic signed [PCM_W-1:0] pcm;
  logic                    last;

  modport source (output valid, output mix_out, output pcm, output last, input ready);
  modport sink (input valid, input mix_out, input pcm, input last, output ready);
endinterface

FILE: design/stdg_ram.sv
// ----------------------------------------------------------------------------
// stdg_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/stdg_sine_lut.sv
// ----------------------------------------------------------------------------
// stdg_sine_lut
// quarter-wave sine memory, loaded after reset, read with mirrored address
// ----------------------------------------------------------------------------
module stdg_sine_lut
  import stdg_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [TABLE_BITS-1:0] rd_idx,
  output logic [SINE_W-1:0]     rd_mag,
  output logic                  busy
);

  localparam int QUARTER = 2 ** (TABLE_BITS - 2);
  localparam int HALF    = 2 ** (TABLE_BITS - 1);
  localparam int QDEPTH  = QUARTER + 1;
  localparam int QW      = $clog2(QDEPTH);

  logic [SINE_W-1:0]     qtab [QDEPTH];
  logic [QW-1:0]         fill_addr;
  logic [TABLE_BITS-2:0] half_pos;
  logic [TABLE_BITS-1:0] mirrored;
  logic [QW-1:0]         quarter_addr;

  for (genvar k = 0; k < QDEPTH; k++) begin : g_tab
    assign qtab[k] = quarter_sine(k, TABLE_BITS);
  end

  // load sweep: one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      fill_addr <= '0;
    end else if (busy) begin
      if (fill_addr == QW'(QUARTER)) begin
        busy <= 1'b0;
      end else begin
        fill_addr <= fill_addr + 1'b1;
      end
    end
  end

  // fold the half-wave position onto the first quarter
  always_comb begin
    half_pos = rd_idx[TABLE_BITS-2:0];
    mirrored = TABLE_BITS'(HALF) - {1'b0, half_pos};
    if ({1'b0, half_pos} <= TABLE_BITS'(QUARTER)) begin
      quarter_addr = QW'(half_pos);
    end else begin
      quarter_addr = QW'(mirrored);
    end
  end

  stdg_ram #(
    .WIDTH (SINE_W),
    .DEPTH (QDEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (busy),
    .wr_addr (fill_addr),
    .wr_data (qtab[fill_addr]),
    .rd_en   (rd_en),
    .rd_addr (quarter_addr),
    .rd_data (rd_mag)
  );

endmodule

FILE: design/swept_tone_decay_generator.sv
// ----------------------------------------------------------------------------
// swept_tone_decay_generator
// swept-frequency tone voice with exponential envelope, mixed into a sum
// ----------------------------------------------------------------------------
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------
//   item    | in  | req_type (start / tick), mix_in
//   result  | out | mix_out, pcm, last (one beat per tick while sounding)
//   cfg     | in  | cfg_write, cfg_index, cfg_data (write only)
//
// one item a cycle while the skid is free; a tick's result is registered in every stage
// stages: control, step+envelope, phase, sine read, scale, mix+output
// the envelope multiply and the phase add are each a registered feedback loop
// after reset the sine memory loads its 2^(TABLE_BITS-2)+1 entries, no beats
// a stalled result waits in the output register; one more lands in the skid
// register, then the whole pipe holds until the skid drains
// ----------------------------------------------------------------------------
`include "swept_tone_decay_generator_assert.svh"

module swept_tone_decay_generator
  import stdg_pkg::*;
#(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  stdg_in_if.sink               item,
  stdg_out_if.source            result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [COUNT_W-1:0]       sample_count;
  logic [STEP_W-1:0]        start_step;
  logic signed [STEP_W-1:0] sweep_delta;
  logic [AMP_W-1:0]         tone_amp;
  logic [AMP_W-1:0]         decay_factor;
  logic                     square_mode;

  // voice state
  logic                 running;
  logic [COUNT_W-1:0]   sample_index;
  logic [STEP_W-1:0]    phase_step;
  logic [PHASE_W-1:0]   phase_acc;
  logic [AMP_W-1:0]     envelope;

  // pipe stages
  logic                    s1_valid, s1_tick, s1_last;
  logic signed [MIX_W-1:0] s1_mix;
  logic                    s2_valid, s2_tick, s2_last;
  logic signed [MIX_W-1:0] s2_mix;
  logic [AMP_W-1:0]        s2_env;
  logic                    s3_valid, s3_last;
  logic signed [MIX_W-1:0] s3_mix;
  logic [AMP_W-1:0]        s3_env;
  logic                    s4_valid, s4_last, s4_neg;
  logic signed [MIX_W-1:0] s4_mix;
  logic [AMP_W-1:0]        s4_env;
  logic                    s5_valid, s5_last, s5_neg;
  logic signed [MIX_W-1:0] s5_mix;
  logic [31:0]             s5_prod;

  // output register and skid
  logic                    out_valid, skid_valid;
  logic signed [MIX_W-1:0] out_mix, skid_mix, new_mix;
  logic signed [PCM_W-1:0] out_pcm, skid_pcm, new_pcm;
  logic                    out_last, skid_last;

  logic                    advance, accept, take;
  logic                    lut_busy;
  logic [SINE_W-1:0]       lut_mag;
  logic [16:0]             count_eff;
  logic [16:0]             index_plus;
  logic                    is_last;
  logic [31:0]             env_prod;
  logic [AMP_W-1:0]        env_decayed;
  logic [SINE_W-1:0]       wave_mag;
  logic                    wave_neg;
  logic [32:0]             contrib_round;
  logic signed [19:0]      contrib;
  logic signed [19:0]      mix_sum;

  // pipe moves whenever the skid is free
  assign advance      = !skid_valid;
  assign item.ready   = advance && !lut_busy;
  assign accept       = item.valid && item.ready;
  assign take         = out_valid && result.ready;

  assign result.valid   = out_valid;
  assign result.mix_out = out_mix;
  assign result.pcm     = out_pcm;
  assign result.last    = out_last;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_W'(1);
      start_step   <= '0;
      sweep_delta  <= '0;
      tone_amp     <= '0;
      decay_factor <= '1;
      square_mode  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[COUNT_W-1:0];
        CFG_START_STEP:   start_step   <= cfg_data[STEP_W-1:0];
        CFG_SWEEP_DELTA:  sweep_delta  <= $signed(cfg_data[STEP_W-1:0]);
        CFG_TONE_AMP:     tone_amp     <= cfg_data[AMP_W-1:0];
        CFG_DECAY_FACTOR: decay_factor <= cfg_data[AMP_W-1:0];
        CFG_SQUARE_MODE:  square_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // end-of-sound test: zero count acts as one, large counts are clamped
  always_comb begin
    count_eff = {2'b00, sample_count};
    if (sample_count == '0) begin
      count_eff = 17'd1;
    end else if (count_eff > 17'(MAX_SAMPLES)) begin
      count_eff = 17'(MAX_SAMPLES);
    end
    index_plus = {2'b00, sample_index} + 17'd1;
    is_last    = index_plus >= count_eff;
  end

  // stage 0: request control, idle ticks are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      sample_index <= '0;
      s1_valid     <= 1'b0;
    end else if (advance) begin
      s1_valid <= 1'b0;
      if (accept) begin
        if (item.req_type == REQ_START) begin
          running      <= 1'b1;
          sample_index <= '0;
          s1_valid     <= 1'b1;
        end else if (running) begin
          s1_valid <= 1'b1;
          if (is_last) begin
            running <= 1'b0;
          end else begin
            sample_index <= index_plus[COUNT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      s1_tick <= (item.req_type == REQ_TICK);
      s1_last <= is_last;
      s1_mix  <= item.mix_in;
    end
  end

  // stage 1: step sweep and envelope decay, the tick sees the old envelope
  assign env_prod    = 32'(envelope) * 32'(decay_factor);
  assign env_decayed = 16'((env_prod + 32'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_valid) begin
        if (s1_tick) begin
          phase_step <= phase_step + STEP_W'(sweep_delta);
          envelope   <= env_decayed;
        end else begin
          phase_step <= start_step;
          envelope   <= tone_amp;
        end
      end
      s2_tick <= s1_tick;
      s2_last <= s1_last;
      s2_mix  <= s1_mix;
      s2_env  <= envelope;
    end
  end

  // stage 2: phase accumulate with the integer part of the new step
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid && s2_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s2_valid) begin
        if (s2_tick) begin
          phase_acc <= phase_acc + phase_step[STEP_W-1:8];
        end else begin
          phase_acc <= '0;
        end
      end
      s3_last <= s2_last;
      s3_mix  <= s2_mix;
      s3_env  <= s2_env;
    end
  end

  // stage 3: sine memory read at the top bits of the phase
  stdg_sine_lut #(
    .TABLE_BITS (TABLE_BITS)
  ) u_lut (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (advance),
    .rd_idx (phase_acc[PHASE_W-1 -: TABLE_BITS]),
    .rd_mag (lut_mag),
    .busy   (lut_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_last <= s3_last;
      s4_mix  <= s3_mix;
      s4_env  <= s3_env;
      s4_neg  <= phase_acc[PHASE_W-1];
    end
  end

  // stage 4: square or sine magnitude times envelope
  always_comb begin
    if (square_mode) begin
      wave_mag = SINE_W'(FULL_SCALE);
      wave_neg = s4_neg || (lut_mag == '0);
    end else begin
      wave_mag = lut_mag;
      wave_neg = s4_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (advance) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_prod <= 32'(wave_mag) * 32'(s4_env);
      s5_neg  <= wave_neg;
      s5_last <= s4_last;
      s5_mix  <= s4_mix;
    end
  end

  // stage 5: round, add to the mix, saturate and clamp
  always_comb begin
    contrib_round = {1'b0, s5_prod} + 33'd16384;
    contrib       = $signed({2'b00, contrib_round[32:15]});
    if (s5_neg) begin
      contrib = -contrib;
    end
    mix_sum = 20'(s5_mix) + contrib;
    if (mix_sum > 20'(MIX_LIMIT)) begin
      new_mix = MIX_W'(MIX_LIMIT);
    end else if (mix_sum < -20'(MIX_LIMIT)) begin
      new_mix = -MIX_W'(MIX_LIMIT);
    end else begin
      new_mix = MIX_W'(mix_sum);
    end
    if (new_mix > MIX_W'(FULL_SCALE)) begin
      new_pcm = PCM_W'(FULL_SCALE);
    end else if (new_mix < -MIX_W'(FULL_SCALE)) begin
      new_pcm = -PCM_W'(FULL_SCALE);
    end else begin
      new_pcm = PCM_W'(new_mix);
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s5_valid;
      end
    end else if (advance && s5_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_mix  <= skid_mix;
        out_pcm  <= skid_pcm;
        out_last <= skid_last;
      end else begin
        out_mix  <= new_mix;
        out_pcm  <= new_pcm;
        out_last <= s5_last;
      end
    end else if (advance) begin
      skid_mix  <= new_mix;
      skid_pcm  <= new_pcm;
      skid_last <= s5_last;
    end
  end

  // checks
  `STDG_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `STDG_ASSERT_NEXT(a_last_tick_stops,
                    accept && item.req_type == REQ_TICK && running && is_last, !running)
  `STDG_ASSERT_NEXT(a_no_items_while_loading, lut_busy, !s1_valid)
  `STDG_ASSERT_NOW(a_pcm_in_range, out_valid,
                   out_pcm <= PCM_W'(FULL_SCALE) && out_pcm >= -PCM_W'(FULL_SCALE))
  `STDG_ASSERT_NOW(a_mix_saturated, out_valid, out_mix != {1'b1, {(MIX_W-1){1'b0}}})

endmodule

FILE: sim/swept_tone_decay_generator_test.sv
// ----------------------------------------------------------------------------
// swept_tone_decay_generator_test
// drives start and tick beats with random gaps and output stalls, predicts
// each mixed sample from a local voice model and compares beat by beat
// ----------------------------------------------------------------------------
module swept_tone_decay_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stdg_pkg::*;

  localparam int TABLE_BITS     = 10;
  localparam int TABLE_SIZE     = 1 << TABLE_BITS;
  localparam int SETTLE_CYCLES  = 10;    // pipe is 6 deep, a little margin
  localparam int WATCHDOG_LIMIT = 3000;  // covers sine load, long stalls, pauses
  localparam int ITEM_TARGET    = 950;
  localparam int PRINT_LIMIT    = 10;

  // one pending request beat; hold makes the driver wait for all results first
  typedef struct {
    req_type_t               kind;
    logic signed [MIX_W-1:0] mix;
    bit                      hold;
  } tone_req_t;

  // one expected result beat
  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic signed [PCM_W-1:0] pcm;
    logic                    last;
  } tone_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stdg_in_if  item_ch ();
  stdg_out_if result_ch ();

  swept_tone_decay_generator dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // request beats waiting for the driver, result beats waiting for the dut
  tone_req_t  stim_q[$];
  tone_beat_t tone_expect_q[$];

  // register shadow, kept in step with every write
  logic [COUNT_W-1:0] cnt_reg        = 15'd1;
  logic [STEP_W-1:0]  start_step_reg = '0;
  logic [STEP_W-1:0]  sweep_reg      = '0;
  logic [AMP_W-1:0]   amp_reg        = '0;
  logic [AMP_W-1:0]   decay_reg      = 16'hFFFF;
  logic               square_reg     = 1'b0;

  // voice state of the local model
  logic [PHASE_W-1:0] voice_phase = '0;
  logic [STEP_W-1:0]  voice_step  = '0;
  logic [AMP_W-1:0]   voice_env   = '0;
  logic [COUNT_W-1:0] voice_index = '0;
  bit                 voice_on    = 1'b0;

  int sine_lut [TABLE_SIZE];

  bit item_taken   = 1'b0;  // request beat accepted at the last rising edge
  bit no_idle      = 1'b0;  // burst phase: no gaps and no stalls
  int gap_left     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int fault_count  = 0;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sine table: q30 taylor series on the quarter wave, scaled to full scale
  // ---------------------------------------------------------------------------
  function automatic int quarter_wave(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    int              n;
    x    = (longint'(k) * 4 * HALF_PI_Q30) / TABLE_SIZE;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= 5; n++) begin
      term = ((((term * x) >> 30) * x) >> 30) / (2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((acc * FULL_SCALE + (64'd1 << 29)) >> 30);
  endfunction

  // ---------------------------------------------------------------------------
  // voice model: a start reloads the voice, a tick while sounding gives a beat
  // ---------------------------------------------------------------------------
  task automatic predict_tone(input req_type_t kind, input logic signed [MIX_W-1:0] mix);
    longint     wave;
    longint     scaled;
    longint     total;
    longint     eff_count;
    tone_beat_t beat;
    if (kind == REQ_START) begin
      voice_phase = '0;
      voice_step  = start_step_reg;
      voice_env   = amp_reg;
      voice_index = '0;
      voice_on    = 1'b1;
    end else if (voice_on) begin
      // sweep the step first, then advance the phase by its integer part
      voice_step  = voice_step + sweep_reg;
      voice_phase = voice_phase + voice_step[STEP_W-1:8];
      wave        = sine_lut[voice_phase[PHASE_W-1 -: TABLE_BITS]];
      if (square_reg) begin
        wave = (wave > 0) ? FULL_SCALE : -FULL_SCALE;
      end
      // magnitude times envelope, rounded, sign restored
      scaled = ((wave < 0 ? -wave : wave) * longint'(voice_env) + 16384) >>> 15;
      if (wave < 0) begin
        scaled = -scaled;
      end
      total = longint'(mix) + scaled;
      if (total > MIX_LIMIT) begin
        total = MIX_LIMIT;
      end
      if (total < -MIX_LIMIT) begin
        total = -MIX_LIMIT;
      end
      beat.mix = total[MIX_W-1:0];
      if (total > FULL_SCALE) begin
        beat.pcm = PCM_W'(FULL_SCALE);
      end else if (total < -FULL_SCALE) begin
        beat.pcm = PCM_W'(-FULL_SCALE);
      end else begin
        beat.pcm = total[PCM_W-1:0];
      end
      // envelope decays after it has been used
      voice_env = AMP_W'((longint'(voice_env) * longint'(decay_reg) + 32768) >> 16);
      // a zero count behaves as one; a count already passed ends on this tick
      eff_count = (cnt_reg == 0) ? 1 : longint'(cnt_reg);
      beat.last = (longint'(voice_index) + 1 >= eff_count);
      if (beat.last) begin
        voice_on = 1'b0;
      end else begin
        voice_index = voice_index + 1'b1;
      end
      tone_expect_q.push_back(beat);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input req_type_t kind, input logic signed [MIX_W-1:0] mix,
                           input bit hold);
    stim_q.push_back('{kind, mix, hold});
  endtask

  // mostly moderate sums, some random bit patterns, some rails
  function automatic logic signed [MIX_W-1:0] pick_mix();
    int v;
    case ($urandom_range(0, 9))
      0:       v = -131072;
      1:       v = 131071;
      2, 3:    v = int'($urandom);
      default: v = int'($urandom_range(0, 80000)) - 40000;
    endcase
    return v[MIX_W-1:0];
  endfunction

  // register write on the falling edge; shadow follows at once since the pipe is empty
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_SAMPLE_COUNT: cnt_reg        = value[COUNT_W-1:0];
      CFG_START_STEP:   start_step_reg = value[STEP_W-1:0];
      CFG_SWEEP_DELTA:  sweep_reg      = value[STEP_W-1:0];
      CFG_TONE_AMP:     amp_reg        = value[AMP_W-1:0];
      CFG_DECAY_FACTOR: decay_reg      = value[AMP_W-1:0];
      CFG_SQUARE_MODE:  square_reg     = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // everything sent, every result back, then wait for the pipe to flush
  task automatic wait_idle();
    while (stim_q.size() != 0 || item_ch.valid || tone_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: beats change on the falling edge, next one after accept
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    tone_req_t nxt;
    int        roll;
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left      <= 0;
    end else if (!item_ch.valid || item_taken) begin
      if (gap_left != 0) begin
        item_ch.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (stim_q.size() != 0 && !(stim_q[0].hold && tone_expect_q.size() != 0)) begin
        nxt = stim_q.pop_front();
        item_ch.valid    <= 1'b1;
        item_ch.req_type <= nxt.kind;
        item_ch.mix_in   <= nxt.mix;
        // gap after this beat: mostly none or short, a few long
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) begin
          gap_left <= 0;
        end else if (roll < 85) begin
          gap_left <= $urandom_range(1, 3);
        end else if (roll < 97) begin
          gap_left <= $urandom_range(4, 12);
        end else begin
          gap_left <= $urandom_range(20, 60);
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result backpressure: short stalls often, long ones now and then
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (no_idle) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (roll < 12) begin
      result_ch.ready <= 1'b0;
      stall_left      <= $urandom_range(0, 2);
    end else if (roll < 15) begin
      result_ch.ready <= 1'b0;
      stall_left      <= $urandom_range(10, 40);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare result beats, then feed accepted request beats to the model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tone_beat_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_ch.valid && item_ch.ready;
      if (result_ch.valid && result_ch.ready) begin
        if (tone_expect_q.size() == 0) begin
          fault_count++;
          if (fault_count <= PRINT_LIMIT) begin
            $display("unexpected beat at %0t: mix_out %0d pcm %0d last %0b", $realtime,
                     $signed(result_ch.mix_out), $signed(result_ch.pcm), result_ch.last);
          end
        end else begin
          want = tone_expect_q.pop_front();
          if (result_ch.mix_out !== want.mix || result_ch.pcm !== want.pcm ||
              result_ch.last !== want.last) begin
            fault_count++;
            if (fault_count <= PRINT_LIMIT) begin
              $display("mismatch at %0t: mix_out %0d/%0d pcm %0d/%0d last %0b/%0b (exp/act)",
                       $realtime, $signed(want.mix), $signed(result_ch.mix_out),
                       $signed(want.pcm), $signed(result_ch.pcm), want.last, result_ch.last);
            end
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        predict_tone(req_type_t'(item_ch.req_type), item_ch.mix_in);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any beat on either channel ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int               k;
    int               j;
    int               v;
    int               sounds;
    int               ticks;
    int               eff;
    int               produced;
    logic [STEP_W-1:0] value;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = CFG_SAMPLE_COUNT;
    cfg_data         = '0;
    item_ch.valid    = 1'b0;
    item_ch.req_type = REQ_TICK;
    item_ch.mix_in   = '0;
    result_ch.ready  = 1'b0;

    // mirror the quarter wave into the full table
    for (k = 0; k < TABLE_SIZE; k++) begin
      j = k % (TABLE_SIZE / 2);
      v = quarter_wave((j <= TABLE_SIZE / 4) ? j : TABLE_SIZE / 2 - j);
      sine_lut[k] = (k < TABLE_SIZE / 2) ? v : -v;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: one sample, zero amplitude
    // tick while idle, then a one-sample sound that pins at the negative rail
    push_item(REQ_TICK, 18'sd131071, 1'b0);
    push_item(REQ_START, '0, 1'b0);
    push_item(REQ_TICK, -18'sd131072, 1'b0);
    push_item(REQ_TICK, 18'sd7, 1'b0);
    wait_idle();

    // zero count acts as one, max step, most negative sweep, envelope above 1.0,
    // instant decay, square wave: sample saturates high
    write_reg(CFG_SAMPLE_COUNT, '0);
    write_reg(CFG_START_STEP, 40'hFF_FFFF_FFFF);
    write_reg(CFG_SWEEP_DELTA, 40'h80_0000_0000);
    write_reg(CFG_TONE_AMP, 40'hFFFF);
    write_reg(CFG_DECAY_FACTOR, '0);
    write_reg(CFG_SQUARE_MODE, 40'd1);
    push_item(REQ_START, '0, 1'b0);
    push_item(REQ_TICK, 18'sd131071, 1'b0);
    push_item(REQ_TICK, -18'sd131072, 1'b0);
    wait_idle();

    // five samples, most positive sweep, unity envelope, no decay, sine
    write_reg(CFG_SAMPLE_COUNT, 40'd5);
    write_reg(CFG_START_STEP, '0);
    write_reg(CFG_SWEEP_DELTA, 40'h7F_FFFF_FFFF);
    write_reg(CFG_TONE_AMP, 40'd32768);
    write_reg(CFG_DECAY_FACTOR, 40'hFFFF);
    write_reg(CFG_SQUARE_MODE, '0);
    push_item(REQ_START, 18'sd100, 1'b0);
    push_item(REQ_TICK, -18'sd131072, 1'b0);
    push_item(REQ_TICK, 18'sd131071, 1'b0);
    push_item(REQ_TICK, '0, 1'b0);
    push_item(REQ_TICK, -18'sd1, 1'b1);      // sender waits for the pipe to drain
    push_item(REQ_TICK, 18'sd1, 1'b0);
    push_item(REQ_TICK, 18'sd2, 1'b0);       // after the last sample
    wait_idle();

    // long sound left running into the random part, so a later count write
    // can land below the current index
    write_reg(CFG_SAMPLE_COUNT, 40'd32767);
    write_reg(CFG_START_STEP, 40'h00_1234_5600);
    write_reg(CFG_SWEEP_DELTA, 40'hFF_FFFF_F000);
    write_reg(CFG_TONE_AMP, 40'd20000);
    write_reg(CFG_DECAY_FACTOR, 40'd65000);
    push_item(REQ_START, '0, 1'b0);
    repeat (4) push_item(REQ_TICK, pick_mix(), 1'b0);
    produced = 19;

    // random phases: new settings, then a few sounds each
    while (produced < ITEM_TARGET) begin
      wait_idle();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 19))
          0:       value = '0;
          1:       value = 40'd32767;
          2:       value = STEP_W'($urandom_range(0, 32767));
          default: value = STEP_W'($urandom_range(1, 40));
        endcase
        write_reg(CFG_SAMPLE_COUNT, value);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:          value = 40'hFF_FFFF_FFFF;
          1:          value = '0;
          2, 3, 4, 5: value = STEP_W'({$urandom, $urandom});
          default:    value = STEP_W'($urandom_range(0, 32'h3FFF_FFFF));
        endcase
        write_reg(CFG_START_STEP, value);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       value = 40'h80_0000_0000;
          1:       value = 40'h7F_FFFF_FFFF;
          2, 3, 4: value = STEP_W'({$urandom, $urandom});
          5, 6, 7: value = '0;
          default: value = STEP_W'(longint'($urandom_range(0, 2000000)) - 1000000);
        endcase
        write_reg(CFG_SWEEP_DELTA, value);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = 40'hFFFF;
          2:       value = STEP_W'($urandom_range(0, 65535));
          3:       value = 40'd32768;
          default: value = STEP_W'($urandom_range(0, 32768));
        endcase
        write_reg(CFG_TONE_AMP, value);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = 40'hFFFF;
          2:       value = STEP_W'($urandom_range(0, 65535));
          default: value = STEP_W'($urandom_range(60000, 65535));
        endcase
        write_reg(CFG_DECAY_FACTOR, value);
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SQUARE_MODE, STEP_W'($urandom_range(0, 1)));
      end

      no_idle = ($urandom_range(0, 5) == 0);
      sounds  = $urandom_range(1, 3);
      repeat (sounds) begin
        // stray tick: ignored when idle, a beat when a sound is still on
        if ($urandom_range(0, 3) == 0) begin
          push_item(REQ_TICK, pick_mix(), 1'b0);
        end
        push_item(REQ_START, pick_mix(), $urandom_range(0, 9) == 0);
        eff = (cnt_reg == 0) ? 1 : int'(cnt_reg);
        if (eff <= 40) begin
          ticks = eff + $urandom_range(0, 2);
        end else begin
          ticks = $urandom_range(5, 40);
        end
        // sometimes cut the sound short with the next start
        if ($urandom_range(0, 5) == 0) begin
          ticks = $urandom_range(0, ticks);
        end
        repeat (ticks) push_item(REQ_TICK, pick_mix(), $urandom_range(0, 24) == 0);
        produced += 1 + ((ticks < eff) ? ticks : eff);
      end
    end

    wait_idle();
    if (fault_count == 0 && tone_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
